>>> src/bgtr_pkg.sv
// bgtr_pkg: shared widths, register indexes and constants of the
// banded gaussian transition row generator; no dependencies
package bgtr_pkg;

	// field widths
	localparam int unsigned RowW   = 11;
	localparam int unsigned MeanW  = 27;
	localparam int unsigned PcW    = 32;
	localparam int unsigned PdW    = 31;
	localparam int unsigned EpsW   = 32;
	localparam int unsigned DensW  = 32;
	localparam int unsigned CntW   = 16;
	localparam int unsigned HwW    = 5;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgW   = 32;

	// arithmetic unit widths
	localparam int unsigned MulW    = 32;
	localparam int unsigned DivNumW = 60;
	localparam int unsigned RootW   = 31;
	localparam int unsigned WideW   = 48;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_MEAN_PREV  = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_MEAN_CUR   = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_PREC_CROSS = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_PREC_DIAG  = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_NUM_ROWS   = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_EPS        = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_UPPER      = 3'd6;

	// fixed-point constants
	localparam logic [31:0] E_INV_Q32      = 32'd1580030169;
	localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
	localparam logic [3:0]  EXP_TERMS      = 4'd12;

	// ceil(2^32 / k), used to divide by the series index k
	function automatic logic [31:0] recip_q32(input logic [3:0] k);
		logic [31:0] r;
		case (k)
			4'd2:    r = 32'd2147483648;
			4'd3:    r = 32'd1431655766;
			4'd4:    r = 32'd1073741824;
			4'd5:    r = 32'd858993460;
			4'd6:    r = 32'd715827883;
			4'd7:    r = 32'd613566757;
			4'd8:    r = 32'd536870912;
			4'd9:    r = 32'd477218589;
			4'd10:   r = 32'd429496730;
			4'd11:   r = 32'd390451573;
			4'd12:   r = 32'd357913942;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

>>> src/banded_gaussian_transition_rows_core.sv
// banded_gaussian_transition_rows_core: sequencer around one shared multiplier,
// a divider and a square root unit; depends on bgtr_pkg, bgtr_mul, bgtr_div, bgtr_root
//
//  channel | signals                                   | direction
//  cfg     | cfg_wen, cfg_index, cfg_data              | in, write only
//  in      | in_valid, in_ready, row_index, restart    | in
//  out     | out_valid, out_ready, row, col, density,  | out
//          | entry_number, last                        |
//
// one row starts with setup (a 60-step divider for the conditional mean), then (h+1)
// cutoff tests and one evaluation per emitted entry, each built on an exponential on
// the shared multiplier (the fraction by a series, the integer part n of the exponent
// by powers of 1/e), plus squaring and scaling per entry
// in_ready is high only while the sequencer is idle; an empty band returns to idle
// the output register holds one finished entry, the sequencer waits for it only when it is full and out_ready is low
// no clearing pass after reset
module banded_gaussian_transition_rows_core import bgtr_pkg::*; #(
	parameter int unsigned MAX_ROWS       = 1024,
	parameter int unsigned MAX_HALF_WIDTH = 31
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [RowW-1:0]    row_index,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [RowW-1:0]    row,
	output logic [RowW-1:0]    col,
	output logic [DensW-1:0]   density,
	output logic [CntW-1:0]    entry_number,
	output logic               last
);

	localparam logic [16:0]    MaxRowsC = 17'(MAX_ROWS);
	localparam logic [HwW-1:0] MaxHwC   = HwW'(MAX_HALF_WIDTH);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_MULQ  = 5'd1;
	localparam logic [4:0] S_DIV   = 5'd2;
	localparam logic [4:0] S_SQST  = 5'd3;
	localparam logic [4:0] S_WAITQ = 5'd4;
	localparam logic [4:0] S_THR   = 5'd5;
	localparam logic [4:0] S_THR2  = 5'd6;
	localparam logic [4:0] S_HT    = 5'd7;
	localparam logic [4:0] S_HX    = 5'd8;
	localparam logic [4:0] S_HCMP  = 5'd9;
	localparam logic [4:0] S_BAND  = 5'd10;
	localparam logic [4:0] S_ENT   = 5'd11;
	localparam logic [4:0] S_SQ1   = 5'd12;
	localparam logic [4:0] S_SQ2   = 5'd13;
	localparam logic [4:0] S_SQ3   = 5'd14;
	localparam logic [4:0] S_SP1   = 5'd15;
	localparam logic [4:0] S_SP2   = 5'd16;
	localparam logic [4:0] S_SP3   = 5'd17;
	localparam logic [4:0] S_EXM   = 5'd18;
	localparam logic [4:0] S_EXD   = 5'd19;
	localparam logic [4:0] S_EXC   = 5'd20;
	localparam logic [4:0] S_EXP   = 5'd21;
	localparam logic [4:0] S_EXP2  = 5'd22;
	localparam logic [4:0] S_DENS  = 5'd23;
	localparam logic [4:0] S_DENS2 = 5'd24;

	localparam logic [32:0] OneQ32 = 33'h1_0000_0000;

	// configuration
	logic signed [MeanW-1:0] mean_prev_q;
	logic signed [MeanW-1:0] mean_cur_q;
	logic signed [PcW-1:0]   prec_cross_q;
	logic [PdW-1:0]          prec_diag_q;
	logic [RowW-1:0]         num_rows_q;
	logic [EpsW-1:0]         eps_q;
	logic                    upper_q;

	// control
	logic [4:0]      state_q, state_d;
	logic            out_valid_q;
	logic [CntW-1:0] entry_count_q;

	// datapath
	logic [RowW-1:0]         b_q;
	logic                    neg_q;
	logic signed [63:0]      m_q;
	logic signed [WideW-1:0] mi_q;
	logic [RootW-1:0]        factor_q;
	logic [62:0]             thr_q;
	logic [HwW-1:0]          h_q;
	logic [RowW-1:0]         a_q;
	logic [RowW-1:0]         hi_q;
	logic [63:0]             mag_q;
	logic [63:0]             sq_q;
	logic [47:0]             s_q;
	logic [63:0]             acc_q;
	logic [31:0]             f_q;
	logic [4:0]              n_q;
	logic [32:0]             r_q;
	logic [3:0]              k_q;
	logic [31:0]             xd_q;
	logic                    ret_q;

	// output register
	logic [RowW-1:0]  row_q;
	logic [RowW-1:0]  col_q;
	logic [DensW-1:0] dens_q;
	logic [CntW-1:0]  num_q;
	logic             last_q;

	// unit connections
	logic [MulW-1:0]    mul_a, mul_b;
	logic [2*MulW-1:0]  mul_p;
	logic               div_start, div_done;
	logic [DivNumW-1:0] quo;
	logic               root_start, root_done;
	logic [RootW-1:0]   root_res;

	// combinational helpers
	logic [PdW-1:0]          pd;
	logic signed [29:0]      d_w;
	logic [28:0]             d_mag;
	logic [PcW-1:0]          pc_mag;
	logic signed [63:0]      q_s;
	logic signed [63:0]      m_w;
	logic [63:0]             m_abs;
	logic [WideW-1:0]        mi_mag;
	logic signed [WideW-1:0] mi_w;
	logic [16:0]             rows;
	logic signed [WideW-1:0] lo_raw, hi_raw, lo_c1, lo_c, hi_c, rows_w, b_w;
	logic                    band_empty;
	logic signed [63:0]      t_w;
	logic [63:0]             mag_w;
	logic [63:0]             sq_w;
	logic [63:0]             xs_w;
	logic [63:0]             x_in;
	logic                    x_big;
	logic [9:0]              hh;
	logic [31:0]             xv;
	logic [31:0]             qe;
	logic [35:0]             qk;
	logic [31:0]             qc;
	logic [DensW-1:0]        dens_w;
	logic                    out_free;
	logic                    out_load;
	logic                    in_acc;
	logic                    exp_hit;

	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == S_DENS2) && out_free;

	// operand preparation
	always_comb begin
		pd     = (prec_diag_q == '0) ? PdW'(1) : prec_diag_q;
		d_w    = $signed({3'b000, b_q, 16'h0000}) - $signed({{3{mean_prev_q[MeanW-1]}}, mean_prev_q});
		d_mag  = d_w[29] ? 29'(-d_w) : d_w[28:0];
		pc_mag = prec_cross_q[PcW-1] ? PcW'(-prec_cross_q) : prec_cross_q;
		q_s    = neg_q ? -$signed({4'b0000, quo}) : $signed({4'b0000, quo});
		m_w    = $signed({{37{mean_cur_q[MeanW-1]}}, mean_cur_q}) - q_s;
		m_abs  = m_q[63] ? 64'(-m_q) : m_q;
		mi_mag = m_abs[63:16];
		mi_w   = m_q[63] ? -$signed(mi_mag) : $signed(mi_mag);
		hh     = 10'(h_q) * 10'(h_q);
	end

	// band limits
	always_comb begin
		rows       = ({6'b0, num_rows_q} > MaxRowsC) ? MaxRowsC : {6'b0, num_rows_q};
		rows_w     = $signed({31'b0, rows});
		b_w        = $signed({37'b0, b_q});
		lo_raw     = mi_q - $signed({43'b0, h_q});
		hi_raw     = mi_q + $signed({43'b0, h_q});
		lo_c1      = (lo_raw < $signed(48'd1)) ? $signed(48'd1) : lo_raw;
		lo_c       = (upper_q && (lo_c1 < b_w)) ? b_w : lo_c1;
		hi_c       = (hi_raw > rows_w) ? rows_w : hi_raw;
		band_empty = lo_c > hi_c;
	end

	// entry exponent and series arithmetic
	always_comb begin
		t_w    = $signed({37'b0, a_q, 16'h0000}) - m_q;
		mag_w  = t_w[63] ? 64'(-t_w) : t_w;
		sq_w   = sq_q + {mul_p[30:0], 33'b0};
		xs_w   = acc_q + {mul_p[31:0], 32'b0};
		x_in   = (state_q == S_HX) ? {mul_p[48:0], 15'b0} : {1'b0, xs_w[63:1]};
		x_big  = |x_in[63:37];
		xv     = r_q[32] ? f_q : mul_p[63:32];
		qe     = mul_p[63:32];
		qk     = 36'(qe) * 36'(k_q);
		qc     = (qk > {4'b0, xd_q}) ? qe - 32'd1 : qe;
		dens_w = r_q[32] ? {1'b0, factor_q} : mul_p[63:32];
		exp_hit = {6'b0, r_q, 24'b0} <= thr_q;
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q) inside
			S_MULQ: begin
				mul_a = pc_mag;
				mul_b = {3'b0, d_mag};
			end
			S_DIV: begin
				mul_a = {1'b0, pd};
				mul_b = INV_TWO_PI_Q32;
			end
			S_THR: begin
				mul_a = eps_q;
				mul_b = {1'b0, factor_q};
			end
			S_HT: begin
				mul_a = {22'b0, hh};
				mul_b = {1'b0, pd};
			end
			S_SQ1: begin
				mul_a = mag_q[31:0];
				mul_b = mag_q[31:0];
			end
			S_SQ2: begin
				mul_a = mag_q[31:0];
				mul_b = mag_q[63:32];
			end
			S_SP1: begin
				mul_a = s_q[31:0];
				mul_b = {1'b0, pd};
			end
			S_SP2: begin
				mul_a = {16'b0, s_q[47:32]};
				mul_b = {1'b0, pd};
			end
			S_EXM: begin
				mul_a = f_q;
				mul_b = r_q[31:0];
			end
			S_EXD: begin
				mul_a = xv;
				mul_b = recip_q32(k_q);
			end
			S_EXP: begin
				mul_a = r_q[31:0];
				mul_b = E_INV_Q32;
			end
			S_DENS, S_DENS2: begin
				mul_a = {1'b0, factor_q};
				mul_b = r_q[31:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign div_start  = state_q == S_DIV;
	assign root_start = state_q == S_SQST;

	bgtr_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (mul_p)
	);

	bgtr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_p[DivNumW-1:0]),
		.divisor  (pd),
		.quotient (quo),
		.done     (div_done)
	);

	bgtr_root u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (mul_p),
		.root     (root_res),
		.done     (root_done)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_acc) state_d = S_MULQ;
			S_MULQ:  state_d = S_DIV;
			S_DIV:   state_d = S_SQST;
			S_SQST:  state_d = S_WAITQ;
			S_WAITQ: if (div_done && root_done) state_d = S_THR;
			S_THR:   state_d = S_THR2;
			S_THR2:  state_d = S_HT;
			S_HT:    state_d = (h_q == MaxHwC) ? S_BAND : S_HX;
			S_HX:    state_d = x_big ? S_HCMP : S_EXM;
			S_HCMP:  state_d = exp_hit ? S_BAND : S_HT;
			S_BAND:  state_d = band_empty ? S_IDLE : S_ENT;
			S_ENT:   state_d = S_SQ1;
			S_SQ1:   state_d = S_SQ2;
			S_SQ2:   state_d = S_SQ3;
			S_SQ3:   state_d = S_SP1;
			S_SP1:   state_d = S_SP2;
			S_SP2:   state_d = S_SP3;
			S_SP3:   state_d = x_big ? S_DENS : S_EXM;
			S_EXM:   state_d = S_EXD;
			S_EXD:   state_d = (k_q == 4'd1) ? S_EXP : S_EXC;
			S_EXC:   state_d = S_EXM;
			S_EXP: begin
				if (n_q == '0) begin
					state_d = ret_q ? S_DENS : S_HCMP;
				end else if (!r_q[32]) begin
					state_d = S_EXP2;
				end
			end
			S_EXP2:  state_d = S_EXP;
			S_DENS:  state_d = S_DENS2;
			S_DENS2: begin
				if (out_free) begin
					state_d = (a_q == hi_q) ? S_IDLE : S_ENT;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			entry_count_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q   <= 1'b1;
				entry_count_q <= entry_count_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_acc && restart) begin
				entry_count_q <= '0;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_prev_q  <= '0;
			mean_cur_q   <= '0;
			prec_cross_q <= '0;
			prec_diag_q  <= PdW'(65536);
			num_rows_q   <= RowW'(1024);
			eps_q        <= EpsW'(43);
			upper_q      <= 1'b1;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_MEAN_PREV:  mean_prev_q  <= $signed(cfg_data[MeanW-1:0]);
				CFG_MEAN_CUR:   mean_cur_q   <= $signed(cfg_data[MeanW-1:0]);
				CFG_PREC_CROSS: prec_cross_q <= $signed(cfg_data[PcW-1:0]);
				CFG_PREC_DIAG:  prec_diag_q  <= cfg_data[PdW-1:0];
				CFG_NUM_ROWS:   num_rows_q   <= cfg_data[RowW-1:0];
				CFG_EPS:        eps_q        <= cfg_data[EpsW-1:0];
				CFG_UPPER:      upper_q      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q) inside
			S_IDLE: begin
				if (in_acc) b_q <= row_index;
			end
			S_MULQ: neg_q <= prec_cross_q[PcW-1] ^ d_w[29];
			S_WAITQ: begin
				m_q      <= m_w;
				factor_q <= root_res;
			end
			S_THR: mi_q <= mi_w;
			S_THR2: begin
				thr_q <= mul_p[62:0];
				h_q   <= '0;
			end
			S_HX, S_SP3: begin
				// exponential start: integer part picks the power, fraction the series
				ret_q <= state_q == S_SP3;
				f_q   <= x_in[31:0];
				n_q   <= x_in[36:32];
				k_q   <= EXP_TERMS;
				r_q   <= x_big ? 33'd0 : OneQ32;
			end
			S_HCMP: begin
				if (!exp_hit) h_q <= h_q + 1'b1;
			end
			S_BAND: begin
				a_q  <= lo_c[RowW-1:0];
				hi_q <= hi_c[RowW-1:0];
			end
			S_ENT: mag_q <= mag_w;
			S_SQ2: sq_q <= mul_p;
			S_SQ3: s_q <= sq_w[63:16];
			S_SP2: acc_q <= mul_p;
			S_EXD: begin
				xd_q <= xv;
				if (k_q == 4'd1) begin
					r_q <= OneQ32 - {1'b0, xv};
					k_q <= k_q - 1'b1;
				end
			end
			S_EXC: begin
				r_q <= OneQ32 - {1'b0, qc};
				k_q <= k_q - 1'b1;
			end
			S_EXP: begin
				if ((n_q != '0) && r_q[32]) begin
					r_q <= {1'b0, E_INV_Q32};
					n_q <= n_q - 1'b1;
				end
			end
			S_EXP2: begin
				r_q <= {1'b0, mul_p[63:32]};
				n_q <= n_q - 1'b1;
			end
			S_DENS2: begin
				if (out_free) a_q <= a_q + 1'b1;
			end
			default: begin
			end
		endcase
		// output register load
		if (out_load) begin
			row_q  <= b_q;
			col_q  <= a_q;
			dens_q <= dens_w;
			num_q  <= entry_count_q;
			last_q <= a_q == hi_q;
		end
	end

	assign in_ready     = state_q == S_IDLE;
	assign out_valid    = out_valid_q;
	assign row          = row_q;
	assign col          = col_q;
	assign density      = dens_q;
	assign entry_number = num_q;
	assign last         = last_q;

	// an accepted item always starts the product for the mean
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == S_MULQ)
		else $error("accepted item did not start the mean product");

	// the counter advances by one on each loaded entry
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> entry_count_q == $past(entry_count_q) + 1'b1)
		else $error("entry counter did not advance");

	// the series never runs with a zero index
	a_series_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXM || state_q == S_EXC) |-> k_q != 4'd0)
		else $error("series index reached zero");

	// loads only into a free output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

endmodule

>>> src/bgtr_mul.sv
// bgtr_mul: shared 32x32 unsigned multiplier with registered product
// depends on bgtr_pkg
module bgtr_mul import bgtr_pkg::*; (
	input  logic              clk,
	input  logic [MulW-1:0]   op_a,
	input  logic [MulW-1:0]   op_b,
	output logic [2*MulW-1:0] prod
);

	logic [2*MulW-1:0] prod_q;

	// one product per cycle
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	assign prod = prod_q;

endmodule

>>> src/bgtr_div.sv
// bgtr_div: restoring divider, one quotient bit per cycle
// depends on bgtr_pkg
module bgtr_div import bgtr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DivNumW-1:0] dividend,
	input  logic [PdW-1:0]     divisor,
	output logic [DivNumW-1:0] quotient,
	output logic               done
);

	localparam int unsigned CntBits = $clog2(DivNumW);

	logic               busy_q;
	logic [CntBits-1:0] cnt_q;
	logic [PdW-1:0]     rem_q;
	logic [PdW-1:0]     div_q;
	logic [DivNumW-1:0] quo_q;
	logic [PdW:0]       rem_sh;
	logic               q_bit;
	logic [PdW-1:0]     rem_nx;

	// shift in next dividend bit and try the subtract
	always_comb begin
		rem_sh = {rem_q, quo_q[DivNumW-1]};
		q_bit  = rem_sh >= {1'b0, div_q};
		rem_nx = q_bit ? PdW'(rem_sh - {1'b0, div_q}) : rem_sh[PdW-1:0];
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CntBits'(DivNumW - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[DivNumW-2:0], q_bit};
		end
	end

	assign quotient = quo_q;
	assign done     = !busy_q;

endmodule

>>> src/bgtr_root.sv
// bgtr_root: integer square root, one result bit per cycle
// depends on bgtr_pkg
module bgtr_root import bgtr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [63:0]      radicand,
	output logic [RootW-1:0] root,
	output logic             done
);

	logic        busy_q;
	logic [63:0] bit_q;
	logic [63:0] v_q;
	logic [63:0] res_q;
	logic [63:0] trial;
	logic        take;

	always_comb begin
		trial = res_q + bit_q;
		take  = v_q >= trial;
	end

	// bit walks down by two places from the top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bit_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			bit_q  <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			bit_q <= bit_q >> 2;
			if (bit_q == 64'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	// remainder and root
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			res_q <= '0;
		end else if (busy_q) begin
			if (take) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	assign root = res_q[RootW-1:0];
	assign done = !busy_q;

endmodule
